/* rtl/s2c_pkg.sv */
// Shared types and constants for the serial-to-CAN frame deframer.
package s2c_pkg;

    localparam logic [7:0] START_TOKEN_RESET = 8'hAA;
    localparam logic [7:0] END_TOKEN_RESET   = 8'hBB;

    localparam logic [7:0] MAX_PAYLOAD_BYTES = 8'd8;
    localparam logic [31:0] STD_ID_MAX       = 32'h0000_07FF;

    localparam logic [4:0] LEN_POS     = 5'd4;
    localparam logic [4:0] ID_POS      = 5'd5;
    localparam logic [4:0] PAYLOAD_POS = 5'd9;

    localparam logic CFG_START_TOKEN = 1'b0;
    localparam logic CFG_END_TOKEN   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_BAD_END       = 2'd1,
        ST_LEN_TOO_LARGE = 2'd2
    } t_status;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_req;

    typedef struct packed {
        logic [7:0] start_token;
        logic [7:0] end_token;
    } t_cfg;

endpackage

/* rtl/serial_to_can_frame_deframer_unit.sv */
// Top level of the serial-to-CAN frame deframer with its configuration registers.
// Throughput: one byte per cycle, also while a result waits, unless that byte closes a frame.
// A closing byte goes from the input register to the result register that drives result valid.
// The input register holds a byte that closes a frame while the result register is full.
// Reset is synchronous, active low; the tokens return to 0xAA and 0xBB and the deframer idles.
module serial_to_can_frame_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_can_id,
    output logic        o_extended,
    output logic [3:0]  o_length,
    output logic [63:0] o_payload,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    s2c_pkg::t_cfg      r_cfg;
    s2c_pkg::t_byte_req byte_req;
    logic               advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_token <= s2c_pkg::START_TOKEN_RESET;
            r_cfg.end_token   <= s2c_pkg::END_TOKEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                s2c_pkg::CFG_START_TOKEN: r_cfg.start_token <= i_cfg_data;
                s2c_pkg::CFG_END_TOKEN:   r_cfg.end_token   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    s2c_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx_valid),
        .o_ready   (o_rx_ready),
        .i_data    (i_rx_byte),
        .i_advance (advance),
        .o_req     (byte_req)
    );

    s2c_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (byte_req),
        .i_cfg       (r_cfg),
        .o_advance   (advance),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_status    (o_status),
        .o_can_id    (o_can_id),
        .o_extended  (o_extended),
        .o_length    (o_length),
        .o_payload   (o_payload)
    );

endmodule

/* rtl/s2c_in_stage.sv */
// Input register that holds one received byte until the deframer takes it.
module s2c_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_data,
    input  logic             i_advance,
    output s2c_pkg::t_byte_req o_req
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;

    assign o_ready = !r_valid || i_advance;

    always_comb begin
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_req.valid = r_valid;
    assign o_req.data  = r_data;

endmodule

/* rtl/s2c_deframer.sv */
// Frame state update for one byte and the registered result request.
module s2c_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  s2c_pkg::t_byte_req i_req,
    input  s2c_pkg::t_cfg      i_cfg,
    output logic               o_advance,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [1:0]         o_status,
    output logic [31:0]        o_can_id,
    output logic               o_extended,
    output logic [3:0]         o_length,
    output logic [63:0]        o_payload
);

    logic        r_phase;
    logic [4:0]  r_byte_index;
    logic [3:0]  r_frame_length;
    logic [31:0] r_id_bytes;
    logic [63:0] r_payload_bytes;

    logic        n_phase;
    logic [4:0]  n_byte_index;
    logic [3:0]  n_frame_length;
    logic [31:0] n_id_bytes;
    logic [63:0] n_payload_bytes;

    logic            r_out_valid;
    logic            n_out_valid;
    s2c_pkg::t_status r_status;
    s2c_pkg::t_status n_status;
    logic [31:0]     r_can_id;
    logic            r_extended;
    logic [3:0]      r_length;
    logic [63:0]     r_payload;

    logic [7:0] b;
    logic       at_len;
    logic       too_long;
    logic [3:0] len_now;
    logic       in_body;
    logic       res_fire;
    logic [1:0] id_lane;
    logic [2:0] pl_lane;
    logic [4:0] id_off;
    logic [4:0] pl_off;

    assign b        = i_req.data;
    assign at_len   = r_byte_index == s2c_pkg::LEN_POS;
    assign too_long = r_phase && at_len && (b > s2c_pkg::MAX_PAYLOAD_BYTES);
    assign len_now  = at_len ? b[3:0] : r_frame_length;
    assign in_body  = r_byte_index < (s2c_pkg::PAYLOAD_POS + {1'b0, len_now});
    assign res_fire = too_long || (r_phase && !in_body);
    assign id_off   = r_byte_index - s2c_pkg::ID_POS;
    assign pl_off   = r_byte_index - s2c_pkg::PAYLOAD_POS;
    assign id_lane  = id_off[1:0];
    assign pl_lane  = pl_off[2:0];

    assign o_advance = i_req.valid && (!res_fire || !r_out_valid || i_res_ready);

    always_comb begin
        n_phase         = r_phase;
        n_byte_index    = r_byte_index;
        n_frame_length  = r_frame_length;
        n_id_bytes      = r_id_bytes;
        n_payload_bytes = r_payload_bytes;
        n_status        = s2c_pkg::ST_OK;
        if (!r_phase) begin
            if (b == i_cfg.start_token) begin
                n_phase         = 1'b1;
                n_byte_index    = '0;
                n_frame_length  = '0;
                n_id_bytes      = '0;
                n_payload_bytes = '0;
            end
        end else if (too_long) begin
            n_phase  = 1'b0;
            n_status = s2c_pkg::ST_LEN_TOO_LARGE;
        end else if (in_body) begin
            n_frame_length = len_now;
            if (r_byte_index >= s2c_pkg::ID_POS && r_byte_index < s2c_pkg::PAYLOAD_POS) begin
                for (int k = 0; k < 4; k++) begin
                    if (id_lane == 2'(k)) begin
                        n_id_bytes[8*k +: 8] = r_id_bytes[8*k +: 8] | b;
                    end
                end
            end else if (r_byte_index >= s2c_pkg::PAYLOAD_POS) begin
                for (int k = 0; k < 8; k++) begin
                    if (pl_lane == 3'(k)) begin
                        n_payload_bytes[8*k +: 8] = r_payload_bytes[8*k +: 8] | b;
                    end
                end
            end
            n_byte_index = r_byte_index + 5'd1;
        end else begin
            n_phase  = 1'b0;
            n_status = (b == i_cfg.end_token) ? s2c_pkg::ST_OK : s2c_pkg::ST_BAD_END;
        end
    end

    always_comb begin
        if (o_advance && res_fire) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= 1'b0;
            r_byte_index    <= '0;
            r_frame_length  <= '0;
            r_id_bytes      <= '0;
            r_payload_bytes <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_advance) begin
                r_phase         <= n_phase;
                r_byte_index    <= n_byte_index;
                r_frame_length  <= n_frame_length;
                r_id_bytes      <= n_id_bytes;
                r_payload_bytes <= n_payload_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && res_fire) begin
            r_status <= n_status;
            if (too_long) begin
                r_can_id   <= '0;
                r_extended <= 1'b0;
                r_length   <= '0;
                r_payload  <= '0;
            end else begin
                r_can_id   <= r_id_bytes;
                r_extended <= r_id_bytes > s2c_pkg::STD_ID_MAX;
                r_length   <= r_frame_length;
                r_payload  <= r_payload_bytes;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_can_id    = r_can_id;
    assign o_extended  = r_extended;
    assign o_length    = r_length;
    assign o_payload   = r_payload;

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= s2c_pkg::PAYLOAD_POS + 5'd8)
        else $error("Byte index ran past the longest frame.");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_length <= s2c_pkg::MAX_PAYLOAD_BYTES[3:0])
        else $error("Stored frame length exceeds the payload capacity.");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == s2c_pkg::ST_LEN_TOO_LARGE) |->
        (r_can_id == '0 && r_payload == '0 && r_length == '0 && !r_extended))
        else $error("Rejected frame reports nonzero fields.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |=> (r_out_valid && $stable(r_can_id)
        && $stable(r_payload)))
        else $error("Pending result request was overwritten.");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && res_fire) |=> !r_phase)
        else $error("Deframer still collecting after a frame closed.");

endmodule
